FILE: src/utf8_sequence_sanitizer_defines.svh
// ---------------------------------------------------------------------------
// UTF-8 sanitizer assertion macros
// Shared concurrent assertion shorthands for the sanitizer modules.
// ---------------------------------------------------------------------------
`ifndef UTF8_SEQUENCE_SANITIZER_DEFINES_SVH
`define UTF8_SEQUENCE_SANITIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define USS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uss assertion failed");

// next-cycle implication, disabled during reset
`define USS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uss assertion failed");

`endif

FILE: src/uss_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 sanitizer package
// Constants and the result group type passed from front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package uss_pkg;

  localparam logic [7:0] REPL_BYTE   = 8'h3F;
  localparam int         QUEUE_DEPTH = 4;

  // up to four output bytes caused by one input beat
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte in the group
    logic            last;      // group ends the string
  } grp_t;

endpackage

FILE: src/uss_front.sv
// ---------------------------------------------------------------------------
// UTF-8 sanitizer front end
// Classifies each accepted byte, holds partial sequences and builds the
// result group for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uss_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    in_byte,
  input  logic          eos,
  output logic          push,
  output uss_pkg::grp_t grp
);

  logic [2:0][7:0] held_r;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      len_r, len_nxt;

  logic       held_any, cont, ascii;
  logic [2:0] fresh_len;
  logic       complete, early, store, brk, fresh_path, fresh_emit, fresh_hold;
  logic [7:0] tail_byte;
  logic       tail_v;
  logic [1:0] pre_cnt;
  logic [2:0] n;

  always_comb begin
    held_any = (cnt_r != 2'd0);
    cont     = (in_byte[7:6] == 2'b10);
    ascii    = !in_byte[7];
    if ((in_byte & 8'hE0) == 8'hC0) begin
      fresh_len = 3'd2;
    end else if ((in_byte & 8'hF0) == 8'hE0) begin
      fresh_len = 3'd3;
    end else if ((in_byte & 8'hF8) == 8'hF0) begin
      fresh_len = 3'd4;
    end else begin
      fresh_len = 3'd0;
    end

    complete   = held_any && cont && (({1'b0, cnt_r} + 3'd1) >= len_r);
    early      = held_any && cont && !complete && eos;
    store      = held_any && cont && !complete && !eos;
    brk        = held_any && !cont;
    fresh_path = !held_any || brk;
    fresh_emit = ascii || (fresh_len == 3'd0) || eos;
    fresh_hold = fresh_path && !fresh_emit;

    if (complete) begin
      tail_byte = in_byte;
    end else if (early || !ascii) begin
      tail_byte = uss_pkg::REPL_BYTE;
    end else begin
      tail_byte = in_byte;
    end
    tail_v  = complete || early || (fresh_path && fresh_emit);
    pre_cnt = (complete || early || brk) ? cnt_r : 2'd0;
    n       = {1'b0, pre_cnt} + {2'b0, tail_v};

    // held bytes go out as-is only when the sequence completes
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pre_cnt) begin
        grp.bytes[i] = complete ? held_r[i] : uss_pkg::REPL_BYTE;
      end else begin
        grp.bytes[i] = tail_byte;
      end
    end
    grp.bytes[3] = tail_byte;
    grp.last_idx = 2'(n - 3'd1);
    grp.last     = eos;
    push         = acc && (n != 3'd0);

    if (store) begin
      cnt_nxt = cnt_r + 2'd1;
      len_nxt = len_r;
    end else if (fresh_hold) begin
      cnt_nxt = 2'd1;
      len_nxt = fresh_len;
    end else begin
      cnt_nxt = 2'd0;
      len_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      len_r <= 3'd0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && fresh_hold) begin
      held_r[0] <= in_byte;
    end
    for (int i = 1; i < 3; i++) begin
      if (acc && store && (cnt_r == 2'(i))) begin
        held_r[i] <= in_byte;
      end
    end
  end

endmodule

FILE: src/uss_queue.sv
// ---------------------------------------------------------------------------
// UTF-8 sanitizer group queue
// Small FIFO of result groups between the front end and the serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_sequence_sanitizer_defines.svh"

module uss_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uss_pkg::grp_t wr_grp,
  input  logic          pop,
  output uss_pkg::grp_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = $clog2(uss_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(uss_pkg::QUEUE_DEPTH + 1);

  uss_pkg::grp_t q_r [uss_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(uss_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(uss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(uss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= wr_grp;
    end
  end

  `USS_ASSERT_NOW(a_no_push_full, clk, rst_n, full, !push)
  `USS_ASSERT_NOW(a_no_pop_empty, clk, rst_n, empty, !pop)
  `USS_ASSERT_NEXT(a_cnt_track, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

FILE: src/uss_back.sv
// ---------------------------------------------------------------------------
// UTF-8 sanitizer back end
// Serializes queued groups into output beats through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_sequence_sanitizer_defines.svh"

module uss_back (
  input  logic          clk,
  input  logic          rst_n,
  input  uss_pkg::grp_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic [1:0] pos_r, pos_nxt;
  logic       load, is_end;

  always_comb begin
    load    = !empty && (!valid_r || out_tready);
    is_end  = (pos_r == head.last_idx);
    pop     = load && is_end;
    pos_nxt = is_end ? 2'd0 : pos_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      pos_r   <= pos_nxt;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.bytes[pos_r];
      last_r <= head.last && is_end;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  // the beat index never runs past the end of the group at the head
  `USS_ASSERT_NOW(a_pos_in_group, clk, rst_n, !empty, pos_r <= head.last_idx)

endmodule

FILE: src/utf8_sequence_sanitizer.sv
// An accepted input beat goes through the group queue to the output register.
// Throughput: one input beat per cycle while the queue is not full, one output
// beat per cycle while out_tready is high; a group of up to 4 bytes goes out one
// byte per output beat, with a 4-group queue taking the burst.
// Reset (rst_n low, synchronous) empties the hold state, queue and output.
// ---------------------------------------------------------------------------
// UTF-8 sequence sanitizer
// Passes structurally well-formed UTF-8 and replaces broken bytes with '?'.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_sequence_sanitizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last_out
);

  uss_pkg::grp_t wr_grp, head;
  logic          acc, push, pop, full, empty;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  uss_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_tdata),
    .eos     (in_tlast),
    .push    (push),
    .grp     (wr_grp)
  );

  uss_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_grp (wr_grp),
    .pop    (pop),
    .head   (head),
    .full   (full),
    .empty  (empty)
  );

  uss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: dv/utf8_sequence_sanitizer_tb.sv
// ---------------------------------------------------------------------------
// UTF-8 sequence sanitizer testbench
// Streams strings of bytes into the sanitizer with random idle and stall
// cycles, predicts every output beat from its own copy of the hold state, and
// checks each output beat, in order, against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_sequence_sanitizer_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int IDLE_PCT     = 19;
  localparam int RANDOM_ITEMS = 150;
  localparam int BURST_ITEMS  = 50;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } san_beat_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tlast   = 1'b0;   // end_of_string
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;           // last_out

  // predicted hold state
  logic [7:0] held [3];
  logic [1:0] held_n  = 2'd0;
  logic [2:0] seq_len = 3'd0;

  san_beat_t sanitized_q [$];
  san_beat_t want_beat;
  int        step_n;
  int        items_sent = 0;
  int        err_cnt    = 0;
  bit        no_idle    = 1'b0;

  utf8_sequence_sanitizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #500_000;
    $display("utf8_sequence_sanitizer_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [8:0] got,
                                 input logic [8:0] want);
    $display("%0t ns: %s: got {last,byte}=%h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic push_beat(input logic [7:0] b);
    san_beat_t e;
    e.data = b;
    e.last = 1'b0;
    sanitized_q.push_back(e);
    step_n++;
  endtask

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    casez (b)
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  // handle a byte with nothing held
  task automatic take_fresh(input logic [7:0] b, input logic eos);
    logic [2:0] len;
    len = lead_length(b);
    if (!b[7]) begin
      push_beat(b);
    end else if (len == 3'd0 || eos) begin
      push_beat(uss_pkg::REPL_BYTE);
    end else begin
      held[0] = b;
      held_n  = 2'd1;
      seq_len = len;
    end
  endtask

  task automatic sanitize_byte(input logic [7:0] b, input logic eos);
    step_n = 0;
    if (held_n != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        if ({1'b0, held_n} + 3'd1 >= seq_len) begin
          for (int i = 0; i < held_n; i++) push_beat(held[i]);
          push_beat(b);
          held_n  = 2'd0;
          seq_len = 3'd0;
        end else if (eos) begin
          for (int i = 0; i <= held_n; i++) push_beat(uss_pkg::REPL_BYTE);
          held_n  = 2'd0;
          seq_len = 3'd0;
        end else begin
          held[held_n] = b;
          held_n = held_n + 2'd1;
        end
      end else begin
        // breaking byte: flush the held bytes as replacements, then start over
        for (int i = 0; i < held_n; i++) push_beat(uss_pkg::REPL_BYTE);
        held_n  = 2'd0;
        seq_len = 3'd0;
        take_fresh(b, eos);
      end
    end else begin
      take_fresh(b, eos);
    end
    if (eos) begin
      held_n  = 2'd0;
      seq_len = 3'd0;
      if (step_n > 0) sanitized_q[sanitized_q.size() - 1].last = 1'b1;
    end
  endtask

  // call right after a rising edge; returns at the edge that takes the beat
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sanitize_byte(b, eos);
    items_sent++;
  endtask

  task automatic send_random_string(input int nchars);
    logic [7:0] s [$];
    int         kind;
    int         len;
    int         ncont;
    for (int c = 0; c < nchars; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(1, 4);
        ncont = len - 1;
      end else if (kind < 80) begin
        // truncated sequence
        len = $urandom_range(2, 4);
        ncont = $urandom_range(0, len - 2);
      end else begin
        len = 0;
        ncont = 0;
      end
      case (len)
        1: s.push_back(8'($urandom_range(1, 127)));
        2: s.push_back({3'b110, 5'($urandom_range(0, 31))});
        3: s.push_back({4'b1110, 4'($urandom_range(0, 15))});
        4: s.push_back({5'b11110, 3'($urandom_range(0, 7))});
        default: begin
          if (kind < 88) s.push_back({2'b10, 6'($urandom_range(0, 63))});
          else if (kind < 94) s.push_back(8'($urandom_range(248, 255)));
          else s.push_back(8'($urandom_range(1, 255)));
        end
      endcase
      for (int k = 0; k < ncont; k++) s.push_back({2'b10, 6'($urandom_range(0, 63))});
    end
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic test_directed;
    // {end_of_string, byte}
    logic [8:0] seq [$] = '{
      // ASCII max, then 2-, 3- and 4-byte sequences, the last completing at the end
      9'h07F, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h180,
      // stray continuations, F8-FF, broken by ASCII, broken by a lead, early end
      9'h080, 9'h0BF, 9'h0F8, 9'h0FF, 9'h0C3, 9'h041, 9'h0E2, 9'h082, 9'h0F4,
      9'h090, 9'h080, 9'h080, 9'h0E1, 9'h1A0,
      // lead as the final byte, ASCII 01 as a whole string
      9'h1C3, 9'h101
    };
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  task automatic test_random_strings;
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) send_random_string($urandom_range(1, 8));
  endtask

  task automatic test_back_to_back;
    int target;
    no_idle = 1'b1;
    target = items_sent + BURST_ITEMS;
    while (items_sent < target) send_random_string($urandom_range(1, 8));
    no_idle = 1'b0;
  endtask

  // output side: random stall, then check each beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_tvalid && out_tready) begin
        if (sanitized_q.size() == 0) begin
          report_mismatch("output beat with nothing predicted", {out_tlast, out_tdata}, 9'h0);
        end else begin
          want_beat = sanitized_q.pop_front();
          if (out_tdata !== want_beat.data)
            report_mismatch("out_byte", {out_tlast, out_tdata}, {want_beat.last, want_beat.data});
          if (out_tlast !== want_beat.last)
            report_mismatch("last_out", {out_tlast, out_tdata}, {want_beat.last, want_beat.data});
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed;
    test_random_strings;
    test_back_to_back;
    in_tvalid <= 1'b0;
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("utf8_sequence_sanitizer_tb: PASS");
    end else begin
      $display("utf8_sequence_sanitizer_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/uss_pkg.sv
src/uss_front.sv
src/uss_queue.sv
src/uss_back.sv
src/utf8_sequence_sanitizer.sv
dv/utf8_sequence_sanitizer_tb.sv
